[design/rser_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rser_pkg
// Shared types and fixed widths of the row span edge rasterizer.
// ----------------------------------------------------------------------------
package rser_pkg;

   localparam int COORD_W    = 18;
   localparam int RADIUS_W   = 17;
   localparam int ROW_W      = 7;
   localparam int OUT_W      = 7;
   localparam int SLOPE_BITS = 16;

   typedef enum logic [1:0] {
      MODE_CLEAR,
      MODE_EDGE,
      MODE_VIEW,
      MODE_READ
   } mode_type;

   // which cell the table port works on
   typedef enum logic [2:0] {
      SEL_A,
      SEL_B,
      SEL_CUR,
      SEL_PREV,
      SEL_READ
   } sel_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_VIEW,
      ST_A_RD,
      ST_A_WR,
      ST_B_RD,
      ST_B_WR,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_SLOPE,
      ST_MUL,
      ST_SETUP,
      ST_WALK,
      ST_C_RD,
      ST_C_WR,
      ST_P_RD,
      ST_P_WR,
      ST_STEP,
      ST_RD_ROW,
      ST_LOAD
   } ctrl_state_type;

   typedef struct packed {
      logic    load;
      logic    clear;
      logic    view;
      logic    div_start;
      logic    slope;
      logic    mul;
      logic    setup;
      logic    step;
      logic    mark_wr;
      logic    out_load;
      sel_type sel;
   } cmd_type;

   typedef struct packed {
      logic dz_zero;
      logic div_done;
      logic walk_done;
      logic cur_ok;
      logic prev_ok;
      logic out_busy;
   } status_type;

endpackage

[design/rser_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rser_if
// Request and response channels of the row span edge rasterizer.
// ----------------------------------------------------------------------------
interface rser_req_if
   import rser_pkg::*;
();
   logic                       valid;
   logic                       ready;
   mode_type                   mode;
   logic signed [COORD_W-1:0]  p1x;
   logic signed [COORD_W-1:0]  p1z;
   logic signed [COORD_W-1:0]  p2x;
   logic signed [COORD_W-1:0]  p2z;
   logic signed [COORD_W-1:0]  center_x;
   logic signed [COORD_W-1:0]  center_z;
   logic        [RADIUS_W-1:0] radius;
   logic        [ROW_W-1:0]    row;

   modport source (
      output valid, mode, p1x, p1z, p2x, p2z, center_x, center_z, radius, row,
      input  ready
   );
   modport sink (
      input  valid, mode, p1x, p1z, p2x, p2z, center_x, center_z, radius, row,
      output ready
   );
endinterface

interface rser_rsp_if
   import rser_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] row_xmin;
   logic [OUT_W-1:0] row_xmax;
   logic             row_empty;
   logic [OUT_W-1:0] bound_zmin;
   logic [OUT_W-1:0] bound_zmax;
   logic [OUT_W-1:0] bound_xmin;
   logic             bounds_empty;

   modport source (
      output valid, row_xmin, row_xmax, row_empty, bound_zmin, bound_zmax,
             bound_xmin, bounds_empty,
      input  ready
   );
   modport sink (
      input  valid, row_xmin, row_xmax, row_empty, bound_zmin, bound_zmax,
             bound_xmin, bounds_empty,
      output ready
   );
endinterface

[design/row_span_edge_rasterizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_span_edge_rasterizer
// Per-row covered span table with edge walk, view square, clear and row read.
// ----------------------------------------------------------------------------
// Usage: one request beat on req_ch carries a mode and all operands; each
// request gives exactly one response beat on rsp_ch with the requested row's
// span and the overall bounds as they stand after the update.
// Sequence, from accept to the response register being loaded:
//   clear, view square : the clear or view state, then row read and load
//   read row           : row read, then load
//   add edge, no row coordinate change : mark both endpoints, read and load
//   add edge, otherwise : mark both endpoints, then the bit-serial slope
//   divider, slope, multiply and setup, then per row walked a read and write
//   of each row of the pair that is on the grid and a step, then a read of
//   the requested row and the load of the response.
// One request is worked at a time; req_ch.ready is high only while idle. The
// response register decouples the sides: a new request may be taken while a
// response waits; a job that finishes while the old beat still waits holds
// in its last state until the receiver takes that beat.
// Reset empties all rows and the bounds at once (flag bits, no clearing pass).
// ----------------------------------------------------------------------------
module row_span_edge_rasterizer
   import rser_pkg::*;
#(
   parameter int GRID_SIZE = 128,
   parameter int FRAC_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   rser_req_if.sink   req_ch,
   rser_rsp_if.source rsp_ch
);
   cmd_type    cmd_w;
   status_type stat_w;

   rser_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.mode),
      .req_ready (req_ch.ready),
      .stat      (stat_w),
      .cmd       (cmd_w)
   );

   rser_dp #(
      .GRID_SIZE (GRID_SIZE),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd_w),
      .stat             (stat_w),
      .req_p1x          (req_ch.p1x),
      .req_p1z          (req_ch.p1z),
      .req_p2x          (req_ch.p2x),
      .req_p2z          (req_ch.p2z),
      .req_center_x     (req_ch.center_x),
      .req_center_z     (req_ch.center_z),
      .req_radius       (req_ch.radius),
      .req_row          (req_ch.row),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_row_xmin     (rsp_ch.row_xmin),
      .rsp_row_xmax     (rsp_ch.row_xmax),
      .rsp_row_empty    (rsp_ch.row_empty),
      .rsp_bound_zmin   (rsp_ch.bound_zmin),
      .rsp_bound_zmax   (rsp_ch.bound_zmax),
      .rsp_bound_xmin   (rsp_ch.bound_xmin),
      .rsp_bounds_empty (rsp_ch.bounds_empty)
   );

   // a pending response beat is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd_w.out_load |-> !stat_w.out_busy)
      else $error("response register loaded while a beat is pending");

   // the divider goes busy right after a start
   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      cmd_w.div_start |=> !stat_w.div_done)
      else $error("divider did not start");

   // operands are captured only on an accepted request beat
   a_load_accept: assert property (@(posedge clock) disable iff (reset)
      cmd_w.load |-> (req_ch.valid && req_ch.ready))
      else $error("operands captured without a request beat");

   // a walk step never coincides with a table write or a response load
   a_step_walk: assert property (@(posedge clock) disable iff (reset)
      cmd_w.step |-> !cmd_w.out_load && !cmd_w.mark_wr)
      else $error("walk step overlaps another command");
endmodule

[design/rser_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rser_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rser_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[design/rser_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rser_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rser_div #(
   parameter int DVD_W = 35,
   parameter int DSR_W = 19
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic             busy,
   output logic [DVD_W-1:0] quotient
);
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DSR_W:0]   trial;
   logic             fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[DVD_W-1]};
      fits   = trial >= {1'b0, dsr_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], fits};
         rem_in = fits ? DSR_W'(trial - {1'b0, dsr_ff}) : trial[DSR_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

[design/rser_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rser_ctrl
// Sequencer: accepts a request and steps the datapath through its mode.
// ----------------------------------------------------------------------------
module rser_ctrl
   import rser_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  mode_type   req_mode,
   output logic       req_ready,
   input  status_type stat,
   output cmd_type    cmd
);
   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_mode)
                  MODE_CLEAR: state_in = ST_CLEAR;
                  MODE_EDGE:  state_in = ST_A_RD;
                  MODE_VIEW:  state_in = ST_VIEW;
                  MODE_READ:  state_in = ST_RD_ROW;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR:    state_in = ST_RD_ROW;
         ST_VIEW:     state_in = ST_RD_ROW;
         ST_A_RD:     state_in = ST_A_WR;
         ST_A_WR:     state_in = ST_B_RD;
         ST_B_RD:     state_in = ST_B_WR;
         ST_B_WR:     state_in = stat.dz_zero ? ST_RD_ROW : ST_DIV_GO;
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: state_in = stat.div_done ? ST_SLOPE : ST_DIV_WAIT;
         ST_SLOPE:    state_in = ST_MUL;
         ST_MUL:      state_in = ST_SETUP;
         ST_SETUP:    state_in = ST_WALK;
         ST_WALK: begin
            if (stat.walk_done) begin
               state_in = ST_RD_ROW;
            end else if (stat.cur_ok) begin
               state_in = ST_C_RD;
            end else if (stat.prev_ok) begin
               state_in = ST_P_RD;
            end
         end
         ST_C_RD:     state_in = ST_C_WR;
         ST_C_WR:     state_in = stat.prev_ok ? ST_P_RD : ST_STEP;
         ST_P_RD:     state_in = ST_P_WR;
         ST_P_WR:     state_in = ST_STEP;
         ST_STEP:     state_in = ST_WALK;
         ST_RD_ROW:   state_in = ST_LOAD;
         ST_LOAD:     state_in = stat.out_busy ? ST_LOAD : ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.sel   = SEL_A;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_CLEAR:  cmd.clear = 1'b1;
         ST_VIEW:   cmd.view  = 1'b1;
         ST_A_RD:   cmd.sel   = SEL_A;
         ST_A_WR: begin
            cmd.sel     = SEL_A;
            cmd.mark_wr = 1'b1;
         end
         ST_B_RD:   cmd.sel   = SEL_B;
         ST_B_WR: begin
            cmd.sel     = SEL_B;
            cmd.mark_wr = 1'b1;
         end
         ST_DIV_GO: cmd.div_start = 1'b1;
         ST_SLOPE:  cmd.slope     = 1'b1;
         ST_MUL:    cmd.mul       = 1'b1;
         ST_SETUP:  cmd.setup     = 1'b1;
         ST_WALK: begin
            // both rows off the grid: just advance
            cmd.step = !stat.walk_done && !stat.cur_ok && !stat.prev_ok;
         end
         ST_C_RD:   cmd.sel = SEL_CUR;
         ST_C_WR: begin
            cmd.sel     = SEL_CUR;
            cmd.mark_wr = 1'b1;
         end
         ST_P_RD:   cmd.sel = SEL_PREV;
         ST_P_WR: begin
            cmd.sel     = SEL_PREV;
            cmd.mark_wr = 1'b1;
         end
         ST_STEP:   cmd.step = 1'b1;
         ST_RD_ROW: cmd.sel  = SEL_READ;
         ST_LOAD: begin
            cmd.sel      = SEL_READ;
            cmd.out_load = !stat.out_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

[design/rser_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rser_dp
// Datapath: span table, bounds, slope divider, edge walker, response register.
// ----------------------------------------------------------------------------
module rser_dp
   import rser_pkg::*;
#(
   parameter int GRID_SIZE = 128,
   parameter int FRAC_BITS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output status_type                 stat,
   input  logic signed [COORD_W-1:0]  req_p1x,
   input  logic signed [COORD_W-1:0]  req_p1z,
   input  logic signed [COORD_W-1:0]  req_p2x,
   input  logic signed [COORD_W-1:0]  req_p2z,
   input  logic signed [COORD_W-1:0]  req_center_x,
   input  logic signed [COORD_W-1:0]  req_center_z,
   input  logic        [RADIUS_W-1:0] req_radius,
   input  logic        [ROW_W-1:0]    req_row,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic        [OUT_W-1:0]    rsp_row_xmin,
   output logic        [OUT_W-1:0]    rsp_row_xmax,
   output logic                       rsp_row_empty,
   output logic        [OUT_W-1:0]    rsp_bound_zmin,
   output logic        [OUT_W-1:0]    rsp_bound_zmax,
   output logic        [OUT_W-1:0]    rsp_bound_xmin,
   output logic                       rsp_bounds_empty
);
   localparam int CW    = $clog2(GRID_SIZE);
   localparam int EW    = COORD_W + 2;
   localparam int CZ_W  = EW - FRAC_BITS;
   localparam int DX_W  = COORD_W + 1;
   localparam int DVD_W = DX_W + SLOPE_BITS;
   localparam int SL_W  = DVD_W + 1;
   localparam int ZF_W  = FRAC_BITS + 2;
   localparam int PR_W  = SL_W + ZF_W;
   localparam int XW    = SL_W + COORD_W - FRAC_BITS + 2;
   localparam int XH_W  = XW - SLOPE_BITS;
   localparam logic signed [EW-1:0]   RND   = EW'((1 << FRAC_BITS) - 1);
   localparam logic signed [EW-1:0]   ONE   = EW'(1 << FRAC_BITS);
   localparam logic signed [PR_W-1:0] RNDP  = PR_W'((1 << FRAC_BITS) - 1);
   localparam logic [XH_W-1:0]        XMAX  = XH_W'(GRID_SIZE - 2);
   localparam logic [CW-1:0]          CMARK = CW'(GRID_SIZE - 2);

   // truncate toward zero to a cell index
   function automatic logic signed [CZ_W-1:0] tcell(input logic signed [EW-1:0] v);
      logic signed [EW-1:0] t;
      t = v + ((v < 0) ? RND : '0);
      t = t >>> FRAC_BITS;
      return t[CZ_W-1:0];
   endfunction

   function automatic logic [CW-1:0] clampc(input logic signed [CZ_W-1:0] v,
                                            input int hi);
      if (v < 0) begin
         return '0;
      end else if (int'(v) > hi) begin
         return CW'(hi);
      end
      return CW'(v);
   endfunction

   function automatic logic rowok(input logic signed [CZ_W-1:0] z);
      return (z >= 0) && (int'(z) <= GRID_SIZE - 2);
   endfunction

   // request registers, endpoints ordered by row
   logic signed [COORD_W-1:0]  ax_ff, az_ff, bx_ff, bz_ff, cx_ff, cz_ff;
   logic        [RADIUS_W-1:0] rad_ff;
   logic        [ROW_W-1:0]    row_ff;
   logic                       swap;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ax_ff  <= swap ? req_p2x : req_p1x;
         az_ff  <= swap ? req_p2z : req_p1z;
         bx_ff  <= swap ? req_p1x : req_p2x;
         bz_ff  <= swap ? req_p1z : req_p2z;
         cx_ff  <= req_center_x;
         cz_ff  <= req_center_z;
         rad_ff <= req_radius;
         row_ff <= req_row;
      end
   end
   assign swap = req_p2z < req_p1z;

   // edge setup
   logic signed [CZ_W-1:0]  m1z, m2z;
   logic        [CW-1:0]    acol, bcol;
   logic signed [DX_W-1:0]  dx, dz;
   logic        [DX_W-1:0]  dx_abs;
   logic        [DVD_W-1:0] quo;
   logic                    div_busy;
   logic signed [EW-1:0]    rem, zf;
   logic signed [ZF_W-1:0]  zfrac;

   assign m1z    = tcell(EW'(az_ff));
   assign m2z    = tcell(EW'(bz_ff));
   assign acol   = clampc(tcell(EW'(ax_ff)), GRID_SIZE - 2);
   assign bcol   = clampc(tcell(EW'(bx_ff)), GRID_SIZE - 2);
   assign dx     = DX_W'(bx_ff) - DX_W'(ax_ff);
   assign dz     = DX_W'(bz_ff) - DX_W'(az_ff);
   assign dx_abs = dx[DX_W-1] ? DX_W'(-dx) : DX_W'(dx);
   assign rem    = EW'(az_ff) - (EW'(m1z) <<< FRAC_BITS);
   assign zf     = ONE - rem;
   assign zfrac  = zf[ZF_W-1:0];

   rser_div #(
      .DVD_W (DVD_W),
      .DSR_W (DX_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({dx_abs, {SLOPE_BITS{1'b0}}}),
      .divisor  (dz),
      .busy     (div_busy),
      .quotient (quo)
   );

   // walker registers
   logic signed [SL_W-1:0] dxdz_ff, dxdz_in, qs;
   logic signed [PR_W-1:0] prod_ff, tq, tsh;
   logic signed [XW-1:0]   x_ff, x_in, xs;
   logic signed [CZ_W-1:0] z_ff, z_in, z_prev;
   logic        [XH_W-1:0] xh;
   logic        [CW-1:0]   wcol;

   always_comb begin
      qs      = SL_W'({1'b0, quo});
      dxdz_in = dx[DX_W-1] ? -qs : qs;
      tq      = prod_ff + ((prod_ff < 0) ? RNDP : '0);
      tsh     = tq >>> FRAC_BITS;
      x_in    = x_ff;
      z_in    = z_ff;
      if (cmd.setup) begin
         x_in = (XW'(ax_ff) <<< (SLOPE_BITS - FRAC_BITS)) + XW'(tsh);
         z_in = m1z + CZ_W'(1);
      end else if (cmd.step) begin
         x_in = x_ff + XW'(dxdz_ff);
         z_in = z_ff + CZ_W'(1);
      end
      xs = x_ff >>> SLOPE_BITS;
      xh = xs[XH_W-1:0];
      if (x_ff < 0) begin
         wcol = '0;
      end else if (xh > XMAX) begin
         wcol = CMARK;
      end else begin
         wcol = CW'(xh);
      end
   end
   assign z_prev = z_ff - CZ_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.slope) begin
         dxdz_ff <= dxdz_in;
      end
      if (cmd.mul) begin
         prod_ff <= PR_W'(zfrac) * PR_W'(dxdz_ff);
      end
      x_ff <= x_in;
      z_ff <= z_in;
   end

   // table port
   logic        [CW-1:0]   mk_col;
   logic signed [CZ_W-1:0] mk_z;
   logic                   mk_ok;
   logic        [CW-1:0]   addr;
   logic        [2*CW-1:0] rdata, wdata;
   logic                   we;

   always_comb begin
      case (cmd.sel)
         SEL_A: begin
            mk_col = acol;
            mk_z   = m1z;
         end
         SEL_B: begin
            mk_col = bcol;
            mk_z   = m2z;
         end
         SEL_CUR: begin
            mk_col = wcol;
            mk_z   = z_ff;
         end
         SEL_PREV: begin
            mk_col = wcol;
            mk_z   = z_prev;
         end
         default: begin
            mk_col = '0;
            mk_z   = '0;
         end
      endcase
      mk_ok = rowok(mk_z);
      addr  = (cmd.sel == SEL_READ) ? CW'(row_ff) : CW'(mk_z);
   end

   // span flags and bounds
   logic [GRID_SIZE-1:0] valid_ff, valid_in, view_ff, view_in;
   logic [CW-1:0]        vxlo_ff, vxlo_in, vxhi_ff, vxhi_in;
   logic [CW-1:0]        zmin_ff, zmin_in, zmax_ff, zmax_in, xmin_ff, xmin_in;
   logic                 bvalid_ff, bvalid_in;
   logic [CW-1:0]        old_lo, old_hi, new_lo, new_hi;
   logic [CW-1:0]        vz_lo, vz_hi, vx_lo, vx_hi;
   logic signed [EW-1:0] rad_e;

   always_comb begin
      rad_e = EW'(rad_ff);
      vz_lo = clampc(tcell(EW'(cz_ff) - rad_e), GRID_SIZE - 1);
      vz_hi = clampc(tcell(EW'(cz_ff) + rad_e), GRID_SIZE - 1);
      vx_lo = clampc(tcell(EW'(cx_ff) - rad_e), GRID_SIZE - 1);
      vx_hi = clampc(tcell(EW'(cx_ff) + rad_e), GRID_SIZE - 1);

      // a row last set by the view square holds its span in vxlo/vxhi
      old_lo = view_ff[addr] ? vxlo_ff : rdata[2*CW-1:CW];
      old_hi = view_ff[addr] ? vxhi_ff : rdata[CW-1:0];
      new_lo = (valid_ff[addr] && old_lo < mk_col) ? old_lo : mk_col;
      new_hi = (valid_ff[addr] && old_hi > mk_col) ? old_hi : mk_col;
      we     = cmd.mark_wr && mk_ok;
      wdata  = {new_lo, new_hi};

      valid_in  = valid_ff;
      view_in   = view_ff;
      vxlo_in   = vxlo_ff;
      vxhi_in   = vxhi_ff;
      zmin_in   = zmin_ff;
      zmax_in   = zmax_ff;
      xmin_in   = xmin_ff;
      bvalid_in = bvalid_ff;
      if (cmd.clear) begin
         valid_in  = '0;
         view_in   = '0;
         bvalid_in = 1'b0;
      end else if (cmd.view) begin
         for (int i = 0; i < GRID_SIZE; i++) begin
            valid_in[i] = (CW'(i) >= vz_lo) && (CW'(i) <= vz_hi);
         end
         view_in   = valid_in;
         vxlo_in   = vx_lo;
         vxhi_in   = vx_hi;
         zmin_in   = vz_lo;
         zmax_in   = vz_hi;
         xmin_in   = vx_lo;
         bvalid_in = 1'b1;
      end else if (we) begin
         valid_in[addr] = 1'b1;
         view_in[addr]  = 1'b0;
         bvalid_in      = 1'b1;
         if (!bvalid_ff) begin
            zmin_in = addr;
            zmax_in = addr;
            xmin_in = mk_col;
         end else begin
            if (addr < zmin_ff) begin
               zmin_in = addr;
            end
            if (addr > zmax_ff) begin
               zmax_in = addr;
            end
            if (mk_col < xmin_ff) begin
               xmin_in = mk_col;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         view_ff   <= '0;
         bvalid_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         view_ff   <= view_in;
         bvalid_ff <= bvalid_in;
      end
      vxlo_ff <= vxlo_in;
      vxhi_ff <= vxhi_in;
      zmin_ff <= zmin_in;
      zmax_ff <= zmax_in;
      xmin_ff <= xmin_in;
   end

   rser_ram #(
      .WIDTH (2 * CW),
      .DEPTH (GRID_SIZE)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (addr),
      .wdata (wdata),
      .raddr (addr),
      .rdata (rdata)
   );

   // response register
   logic             rvalid_ff, rvalid_in;
   logic [OUT_W-1:0] rxmin_ff, rxmax_ff, bzmin_ff, bzmax_ff, bxmin_ff;
   logic             rempty_ff, bempty_ff;
   logic             rd_hit;

   assign rd_hit    = (int'(row_ff) < GRID_SIZE) && valid_ff[addr];
   assign rvalid_in = cmd.out_load || (rvalid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff <= 1'b0;
      end else begin
         rvalid_ff <= rvalid_in;
      end
      if (cmd.out_load) begin
         rxmin_ff  <= rd_hit ? OUT_W'(old_lo) : '0;
         rxmax_ff  <= rd_hit ? OUT_W'(old_hi) : '0;
         rempty_ff <= !rd_hit;
         bzmin_ff  <= bvalid_ff ? OUT_W'(zmin_ff) : '0;
         bzmax_ff  <= bvalid_ff ? OUT_W'(zmax_ff) : '0;
         bxmin_ff  <= bvalid_ff ? OUT_W'(xmin_ff) : '0;
         bempty_ff <= !bvalid_ff;
      end
   end

   assign rsp_valid        = rvalid_ff;
   assign rsp_row_xmin     = rxmin_ff;
   assign rsp_row_xmax     = rxmax_ff;
   assign rsp_row_empty    = rempty_ff;
   assign rsp_bound_zmin   = bzmin_ff;
   assign rsp_bound_zmax   = bzmax_ff;
   assign rsp_bound_xmin   = bxmin_ff;
   assign rsp_bounds_empty = bempty_ff;

   always_comb begin
      stat.dz_zero   = (dz == '0);
      stat.div_done  = !div_busy;
      stat.walk_done = z_ff > m2z;
      stat.cur_ok    = rowok(z_ff);
      stat.prev_ok   = rowok(z_prev);
      stat.out_busy  = rvalid_ff && !rsp_ready;
   end
endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives clear, edge, view square and read requests into the row span edge
// rasterizer and checks every response against a span table kept here.
// ----------------------------------------------------------------------------
module testbench;
   import rser_pkg::*;

   localparam int GRID = 128;
   localparam int FRAC = 8;
   localparam int WATCHDOG = 20000;

   typedef struct packed {
      logic [OUT_W-1:0] row_xmin;
      logic [OUT_W-1:0] row_xmax;
      logic             row_empty;
      logic [OUT_W-1:0] bound_zmin;
      logic [OUT_W-1:0] bound_zmax;
      logic [OUT_W-1:0] bound_xmin;
      logic             bounds_empty;
   } span_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rser_req_if req_ch ();
   rser_rsp_if rsp_ch ();

   row_span_edge_rasterizer u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // span table as the block should hold it
   bit        row_cov [GRID];
   int        row_lo [GRID];
   int        row_hi [GRID];
   int        least_row_q, greatest_row_q, least_col_q;
   bit        bounds_set;
   span_rsp_t span_expect_q[$];
   int        mismatch_cnt = 0;
   int        idle_cycles = 0;
   bit        stall_random = 1'b1;

   function automatic longint trunc_cell(longint v, int frac);
      return v / (longint'(1) << frac);
   endfunction

   function automatic void table_clear();
      for (int i = 0; i < GRID; i++) begin
         row_cov[i] = 1'b0;
         row_lo[i] = 0;
         row_hi[i] = 0;
      end
   endfunction

   function automatic void mark_span_cell(longint x, longint z);
      int c, r;
      if (z < 0 || z > GRID - 2) return;
      if (x < 0) x = 0;
      if (x > GRID - 2) x = GRID - 2;
      c = int'(x);
      r = int'(z);
      if (!bounds_set) begin
         least_row_q = r;
         greatest_row_q = r;
         least_col_q = c;
         bounds_set = 1'b1;
      end else begin
         if (r < least_row_q) least_row_q = r;
         if (r > greatest_row_q) greatest_row_q = r;
         if (c < least_col_q) least_col_q = c;
      end
      if (!row_cov[r]) begin
         row_cov[r] = 1'b1;
         row_lo[r] = c;
         row_hi[r] = c;
      end else begin
         if (c < row_lo[r]) row_lo[r] = c;
         if (c > row_hi[r]) row_hi[r] = c;
      end
   endfunction

   function automatic void walk_edge(longint ax, longint az, longint bx, longint bz);
      longint one, t, m1z, m2z, dx, dz, dxdz, zfrac, x, c;
      one = longint'(1) << FRAC;
      if (bz < az) begin
         t = ax; ax = bx; bx = t;
         t = az; az = bz; bz = t;
      end
      m1z = trunc_cell(az, FRAC);
      m2z = trunc_cell(bz, FRAC);
      mark_span_cell(trunc_cell(ax, FRAC), m1z);
      mark_span_cell(trunc_cell(bx, FRAC), m2z);
      dx = bx - ax;
      dz = bz - az;
      if (dz == 0) return;
      dxdz = (dx * (longint'(1) << SLOPE_BITS)) / dz;
      zfrac = one - (az - m1z * one);
      x = ax * (longint'(1) << (SLOPE_BITS - FRAC)) + (zfrac * dxdz) / one;
      for (longint z = m1z + 1; z <= m2z; z++) begin
         c = trunc_cell(x, SLOPE_BITS);
         mark_span_cell(c, z);
         mark_span_cell(c, z - 1);
         x += dxdz;
      end
   endfunction

   function automatic longint clamp_grid(longint v);
      if (v < 0) return 0;
      if (v > GRID - 1) return GRID - 1;
      return v;
   endfunction

   function automatic void set_view_box(longint cx, longint cz, longint r);
      longint zmin, zmax, xmin, xmax;
      zmin = clamp_grid(trunc_cell(cz - r, FRAC));
      zmax = clamp_grid(trunc_cell(cz + r, FRAC));
      xmin = clamp_grid(trunc_cell(cx - r, FRAC));
      xmax = clamp_grid(trunc_cell(cx + r, FRAC));
      table_clear();
      least_row_q = int'(zmin);
      greatest_row_q = int'(zmax);
      least_col_q = int'(xmin);
      bounds_set = 1'b1;
      for (longint z = zmin; z <= zmax; z++) begin
         row_cov[z] = 1'b1;
         row_lo[z] = int'(xmin);
         row_hi[z] = int'(xmax);
      end
   endfunction

   function automatic span_rsp_t predict_span(mode_type md,
         logic signed [COORD_W-1:0] ax, logic signed [COORD_W-1:0] az,
         logic signed [COORD_W-1:0] bx, logic signed [COORD_W-1:0] bz,
         logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cz,
         logic [RADIUS_W-1:0] rad, logic [ROW_W-1:0] rd);
      span_rsp_t res;
      case (md)
         MODE_CLEAR: begin
            table_clear();
            least_row_q = 0;
            greatest_row_q = 0;
            least_col_q = 0;
            bounds_set = 1'b0;
         end
         MODE_EDGE: walk_edge(longint'(ax), longint'(az), longint'(bx), longint'(bz));
         MODE_VIEW: set_view_box(longint'(cx), longint'(cz), longint'(rad));
         default: ;
      endcase
      res = '0;
      if (row_cov[rd]) begin
         res.row_xmin = row_lo[rd][OUT_W-1:0];
         res.row_xmax = row_hi[rd][OUT_W-1:0];
      end else begin
         res.row_empty = 1'b1;
      end
      if (bounds_set) begin
         res.bound_zmin = least_row_q[OUT_W-1:0];
         res.bound_zmax = greatest_row_q[OUT_W-1:0];
         res.bound_xmin = least_col_q[OUT_W-1:0];
      end else begin
         res.bounds_empty = 1'b1;
      end
      return res;
   endfunction

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.mode <= MODE_CLEAR;
      req_ch.p1x <= '0;
      req_ch.p1z <= '0;
      req_ch.p2x <= '0;
      req_ch.p2z <= '0;
      req_ch.center_x <= '0;
      req_ch.center_z <= '0;
      req_ch.radius <= '0;
      req_ch.row <= '0;
      table_clear();
      least_row_q = 0;
      greatest_row_q = 0;
      least_col_q = 0;
      bounds_set = 1'b0;
   end

   // receiver stall pattern: bursts of stall, sometimes always ready
   int stall_len = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (!stall_random) begin
         rsp_ch.ready <= 1'b1;
      end else if (stall_len > 0) begin
         stall_len <= stall_len - 1;
         rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_len <= $urandom_range(0, 12);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // response checker
   always @(posedge clock) begin
      span_rsp_t got, exp;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.row_xmin, rsp_ch.row_xmax, rsp_ch.row_empty, rsp_ch.bound_zmin,
                 rsp_ch.bound_zmax, rsp_ch.bound_xmin, rsp_ch.bounds_empty};
         if (span_expect_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) $display("unexpected response beat %p", got);
         end else begin
            exp = span_expect_q.pop_front();
            if (got !== exp) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10) $display("response mismatch: expected %p got %p", exp, got);
            end
         end
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   int burst_left = 0;

   // valid stays high between beats of a burst and drops only for a gap
   task automatic send_item(mode_type md, int ax, int az, int bx, int bz,
                            int cx, int cz, int rad, int rd);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.mode <= md;
      req_ch.p1x <= ax[COORD_W-1:0];
      req_ch.p1z <= az[COORD_W-1:0];
      req_ch.p2x <= bx[COORD_W-1:0];
      req_ch.p2z <= bz[COORD_W-1:0];
      req_ch.center_x <= cx[COORD_W-1:0];
      req_ch.center_z <= cz[COORD_W-1:0];
      req_ch.radius <= rad[RADIUS_W-1:0];
      req_ch.row <= rd[ROW_W-1:0];
      do @(posedge clock); while (!req_ch.ready);
      span_expect_q.push_back(predict_span(md, ax[COORD_W-1:0], az[COORD_W-1:0],
                                           bx[COORD_W-1:0], bz[COORD_W-1:0],
                                           cx[COORD_W-1:0], cz[COORD_W-1:0],
                                           rad[RADIUS_W-1:0], rd[ROW_W-1:0]));
   endtask

   function automatic int rand_coord();
      case ($urandom_range(0, 4))
         0: return $signed($urandom_range(0, 262143) - 131072);
         1: return $urandom_range(0, 127 * 256 + 255);
         2: return int'($urandom_range(0, 40 * 256)) - 5 * 256;
         default: return $urandom_range(0, 130 * 256) - 512;
      endcase
   endfunction

   // mostly a near edge: a small row span keeps the walk short
   task automatic send_edge(int rd);
      int ax, az, bx, bz;
      ax = rand_coord();
      az = rand_coord();
      bx = rand_coord();
      if ($urandom_range(0, 3) == 0) bz = rand_coord();
      else bz = az + int'($urandom_range(0, 24 * 256)) - 12 * 256;
      if (bz > 131071) bz = 131071;
      if (bz < -131072) bz = -131072;
      send_item(MODE_EDGE, ax, az, bx, bz, rand_coord(), rand_coord(),
                $urandom_range(0, 131071), rd);
   endtask

   task automatic test_directed();
      send_item(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0);
      send_item(MODE_EDGE, 5 * 256, 10 * 256, 5 * 256 + 128, 10 * 256 + 77, 0, 0, 0, 10);
      send_item(MODE_EDGE, 20 * 256, 30 * 256 + 200, 2 * 256 + 9, 12 * 256 + 3, 0, 0, 0, 20);
      send_item(MODE_EDGE, -131072, -131072, 131071, 131071, 0, 0, 0, 126);
      send_item(MODE_EDGE, -700, -300, 300, 700, 0, 0, 0, 0);
      send_item(MODE_EDGE, 100 * 256, 125 * 256 + 255, 200 * 256, 127 * 256 + 3, 0, 0, 0, 127);
      send_item(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 127);
      send_item(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 125);
      send_item(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 125);
      send_item(MODE_VIEW, 0, 0, 0, 0, 64 * 256, 64 * 256, 10 * 256 + 128, 60);
      send_item(MODE_EDGE, 50 * 256, 0, 70 * 256, 3 * 256, 0, 0, 0, 1);
      send_item(MODE_VIEW, 0, 0, 0, 0, -131072, -131072, 131071, 127);
      send_item(MODE_VIEW, 0, 0, 0, 0, 131071, 131071, 131071, 0);
      send_item(MODE_VIEW, 0, 0, 0, 0, -300, 300, 0, 1);
      send_item(MODE_VIEW, 0, 0, 0, 0, 131071, -131072, 0, 127);
      send_item(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 127);
      send_item(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
      send_item(MODE_EDGE, -131072, 2 * 256, -131072, 2 * 256, 0, 0, 0, 2);
      send_item(MODE_EDGE, 131071, 5 * 256 + 1, 131071, 2 * 256 + 255, 0, 0, 0, 5);
      send_item(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 3);
   endtask

   task automatic test_random(int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         stall_random = (i % 200) < 160;
         pick = $urandom_range(0, 19);
         if (pick == 0) send_item(MODE_CLEAR, rand_coord(), rand_coord(), rand_coord(),
                                  rand_coord(), 0, 0, 0, $urandom_range(0, 127));
         else if (pick < 3) send_item(MODE_VIEW, rand_coord(), rand_coord(), rand_coord(),
                                      rand_coord(), rand_coord(), rand_coord(),
                                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                                                  : $urandom_range(0, 4096),
                                      $urandom_range(0, 127));
         else if (pick < 8) send_item(MODE_READ, rand_coord(), rand_coord(), rand_coord(),
                                      rand_coord(), rand_coord(), rand_coord(),
                                      $urandom_range(0, 131071), $urandom_range(0, 127));
         else send_edge($urandom_range(0, 127));
      end
      stall_random = 1'b1;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(880);
      req_ch.valid <= 1'b0;
      while (span_expect_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatch_cnt == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
